/* hdl/wsfu_pkg.sv */
`default_nettype none

package wsfu_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT     = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

/* hdl/wsfu_parser.sv */
`default_nettype none

module wsfu_parser #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   byte_in,
    output wsfu_pkg::res_t    res
);

    wsfu_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]              ext_bytes_left_reg, ext_bytes_left_next;
    logic [LENGTH_BITS-1:0]  payload_left_reg, payload_left_next;
    logic [31:0]             mask_key_reg, mask_key_next;
    logic [1:0]              mask_pos_reg, mask_pos_next;
    logic [6:0]              len7;
    logic                    is_last;
    logic [7:0]              key_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= wsfu_pkg::PH_HDR0;
            ext_bytes_left_reg <= '0;
            payload_left_reg   <= '0;
            mask_key_reg       <= '0;
            mask_pos_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            ext_bytes_left_reg <= ext_bytes_left_next;
            payload_left_reg   <= payload_left_next;
            mask_key_reg       <= mask_key_next;
            mask_pos_reg       <= mask_pos_next;
        end
    end

    always_comb
    begin
        len7     = byte_in[6:0];
        is_last  = (payload_left_reg[LENGTH_BITS-1:1] == '0);
        key_byte = mask_key_reg[8*(3-mask_pos_reg) +: 8];

        phase_next          = phase_reg;
        ext_bytes_left_next = ext_bytes_left_reg;
        payload_left_next   = payload_left_reg;
        mask_key_next       = mask_key_reg;
        mask_pos_next       = mask_pos_reg;
        res.emit            = 1'b0;
        res.data            = byte_in ^ key_byte;
        res.last            = is_last;

        unique case (phase_reg)
            wsfu_pkg::PH_LEN:
            begin
                mask_pos_next = '0;
                mask_key_next = '0;
                if (len7 == wsfu_pkg::LEN7_EXT16)
                begin
                    payload_left_next   = '0;
                    ext_bytes_left_next = wsfu_pkg::EXT16_BYTES;
                    phase_next          = wsfu_pkg::PH_EXT;
                end
                else if (len7 == wsfu_pkg::LEN7_EXT64)
                begin
                    payload_left_next   = '0;
                    ext_bytes_left_next = wsfu_pkg::EXT64_BYTES;
                    phase_next          = wsfu_pkg::PH_EXT;
                end
                else
                begin
                    payload_left_next   = LENGTH_BITS'(len7);
                    ext_bytes_left_next = '0;
                    phase_next          = wsfu_pkg::PH_KEY;
                end
            end
            wsfu_pkg::PH_EXT:
            begin
                if (payload_left_reg[LENGTH_BITS-1 -: 8] != '0)
                begin
                    payload_left_next = '1;
                end
                else
                begin
                    payload_left_next = {payload_left_reg[LENGTH_BITS-9:0], byte_in};
                end
                ext_bytes_left_next = ext_bytes_left_reg - 4'd1;
                if (ext_bytes_left_next == '0)
                begin
                    phase_next = wsfu_pkg::PH_KEY;
                end
            end
            wsfu_pkg::PH_KEY:
            begin
                mask_key_next = {mask_key_reg[23:0], byte_in};
                mask_pos_next = mask_pos_reg + 2'd1;
                if (mask_pos_next == '0)
                begin
                    phase_next = (payload_left_reg == '0) ? wsfu_pkg::PH_HDR0
                                                          : wsfu_pkg::PH_PAYLOAD;
                end
            end
            wsfu_pkg::PH_PAYLOAD:
            begin
                res.emit = 1'b1;
                if (is_last)
                begin
                    payload_left_next = '0;
                    mask_pos_next     = '0;
                    phase_next        = wsfu_pkg::PH_HDR0;
                end
                else
                begin
                    payload_left_next = payload_left_reg - LENGTH_BITS'(1);
                    mask_pos_next     = mask_pos_reg + 2'd1;
                end
            end
            default:
            begin
                phase_next          = wsfu_pkg::PH_LEN;
                ext_bytes_left_next = '0;
                payload_left_next   = '0;
                mask_pos_next       = '0;
            end
        endcase
    end

    // The extended length phase always has at least one byte still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfu_pkg::PH_EXT |-> ext_bytes_left_reg != '0)
        else $error("extended length phase with no bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.emit && res.last
        |=> phase_reg == wsfu_pkg::PH_HDR0 && mask_pos_reg == '0)
        else $error("frame did not close after its last payload byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == wsfu_pkg::PH_KEY && mask_pos_reg == 2'd3
        && payload_left_reg == '0
        |=> phase_reg == wsfu_pkg::PH_HDR0)
        else $error("empty frame did not return to the header");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == wsfu_pkg::PH_LEN |=> mask_pos_reg == '0)
        else $error("mask position not cleared at the length byte");

endmodule

`default_nettype wire

/* hdl/websocket_frame_unmasker_unit.sv */
// A payload byte waits in the input register and is unmasked into the output register.
// Throughput: one byte per cycle unless the output stalls; the input register advances
// whenever the output register is empty or taken; header bytes never wait on the output.
// Reset: asynchronous and active low; it clears the frame phase, length, mask key,
// mask position and both valid flags, so the block then expects the first header byte.
`default_nettype none

module websocket_frame_unmasker_unit #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      payload_byte,
    output logic            frame_end
);

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            out_valid_reg;
    logic [7:0]      payload_byte_reg;
    logic            frame_end_reg;
    logic            out_free;
    logic            step;
    wsfu_pkg::res_t  res;

    wsfu_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        step     = in_valid_reg && (!res.emit || out_free);
        in_ready = !in_valid_reg || step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step && res.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
        if (out_free && step && res.emit)
        begin
            payload_byte_reg <= res.data;
            frame_end_reg    <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_byte_reg;
    assign frame_end    = frame_end_reg;

endmodule

`default_nettype wire
